// ----- rtl/http_request_line_check_unit_assert.svh -----
// Assertion macros for the request line check RTL.
`ifndef HTTP_REQUEST_LINE_CHECK_UNIT_ASSERT_SVH
`define HTTP_REQUEST_LINE_CHECK_UNIT_ASSERT_SVH

// Check a property on every rising edge of clk, muted while rst is high.
`define HRLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define HRLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/hrlc_pkg.sv -----
package hrlc_pkg;

  localparam int unsigned LEN_FIELD_W = 12;
  localparam logic [2:0] PREFIX_LEN = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_NO_PATH    = 3'd1;
  localparam logic [2:0] STS_NO_VERSION = 3'd2;
  localparam logic [2:0] STS_BAD_PREFIX = 3'd3;
  localparam logic [2:0] STS_NO_DOT     = 3'd4;
  localparam logic [2:0] STS_BAD_MAJOR  = 3'd5;
  localparam logic [2:0] STS_BAD_MINOR  = 3'd6;

  typedef enum logic [5:0] {
    PH_VERB   = 6'b000001,
    PH_PATH   = 6'b000010,
    PH_PREFIX = 6'b000100,
    PH_DOT    = 6'b001000,
    PH_MINOR  = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
  } req_t;

  typedef struct packed {
    logic [2:0]             status_code;
    logic [3:0]             major_version;
    logic [3:0]             minor_version;
    logic [LEN_FIELD_W-1:0] verb_length;
    logic [LEN_FIELD_W-1:0] path_length;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] prefix_pos;
    logic [7:0] prev_byte;
    logic [3:0] major;
    logic [3:0] minor;
    logic [2:0] status;
    logic       ended;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:      PH_VERB,
    prefix_pos: 3'd0,
    prev_byte:  8'h00,
    major:      4'd0,
    minor:      4'd0,
    status:     STS_OK,
    ended:      1'b0
  };

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h48;  // H
      3'd1:    c = 8'h54;  // T
      3'd2:    c = 8'h54;  // T
      3'd3:    c = 8'h50;  // P
      3'd4:    c = 8'h2F;  // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/hrlc_parse.sv -----
module hrlc_parse #(
  parameter int unsigned LENGTH_WIDTH = 12
) (
  input  hrlc_pkg::state_t         st,
  input  logic [LENGTH_WIDTH-1:0]  verb_cnt,
  input  logic [LENGTH_WIDTH-1:0]  path_cnt,
  input  logic [7:0]               line_byte,
  input  logic                     line_end,
  output hrlc_pkg::state_t         st_next,
  output logic [LENGTH_WIDTH-1:0]  verb_next,
  output logic [LENGTH_WIDTH-1:0]  path_next,
  output hrlc_pkg::res_t           res_next
);
  import hrlc_pkg::*;

  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

  logic [2:0]              status;
  state_t                  st_upd;
  logic [LENGTH_WIDTH-1:0] verb_upd;
  logic [LENGTH_WIDTH-1:0] path_upd;

  always_comb begin
    st_upd   = st;
    verb_upd = verb_cnt;
    path_upd = path_cnt;
    if (!st.ended) begin
      if (line_byte == CH_NUL) begin
        st_upd.ended = 1'b1;
      end else begin
        unique case (st.phase)
          PH_VERB: begin
            if (line_byte == CH_SPACE) begin
              st_upd.phase = PH_PATH;
            end else if (verb_cnt != LEN_MAX) begin
              verb_upd = verb_cnt + 1'b1;
            end
          end
          PH_PATH: begin
            if (line_byte == CH_SPACE) begin
              st_upd.phase      = PH_PREFIX;
              st_upd.prefix_pos = 3'd0;
            end else if (path_cnt != LEN_MAX) begin
              path_upd = path_cnt + 1'b1;
            end
          end
          PH_PREFIX: begin
            if ((st.prefix_pos >= PREFIX_LEN) || (line_byte != prefix_char(st.prefix_pos))) begin
              st_upd.status = STS_BAD_PREFIX;
              st_upd.phase  = PH_DONE;
            end else begin
              st_upd.prefix_pos = st.prefix_pos + 3'd1;
              if (st.prefix_pos == PREFIX_LEN - 3'd1) begin
                st_upd.phase = PH_DOT;
              end
            end
          end
          PH_DOT: begin
            if (line_byte == CH_DOT) begin
              if (!is_digit(st.prev_byte)) begin
                st_upd.status = STS_BAD_MAJOR;
                st_upd.phase  = PH_DONE;
              end else begin
                st_upd.major = 4'(st.prev_byte - CH_ZERO);
                st_upd.phase = PH_MINOR;
              end
            end
          end
          PH_MINOR: begin
            st_upd.phase = PH_DONE;
            if (is_digit(line_byte)) begin
              st_upd.minor  = 4'(line_byte - CH_ZERO);
              st_upd.status = STS_OK;
            end else begin
              st_upd.status = STS_BAD_MINOR;
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
        st_upd.prev_byte = line_byte;
      end
    end
  end

  // Early end of line: the phase reached names the error.
  always_comb begin
    unique case (st_upd.phase)
      PH_VERB:   status = STS_NO_PATH;
      PH_PATH:   status = STS_NO_VERSION;
      PH_PREFIX: status = STS_BAD_PREFIX;
      PH_DOT:    status = STS_NO_DOT;
      PH_MINOR:  status = STS_BAD_MINOR;
      default:   status = st_upd.status;
    endcase
  end

  always_comb begin
    res_next.status_code   = status;
    res_next.major_version = (status == STS_OK) ? st_upd.major : 4'd0;
    res_next.minor_version = (status == STS_OK) ? st_upd.minor : 4'd0;
    res_next.verb_length   = LEN_FIELD_W'(verb_upd);
    res_next.path_length   = LEN_FIELD_W'(path_upd);
  end

  // Clear everything once a line has produced its result.
  always_comb begin
    if (line_end) begin
      st_next   = ST_RESET;
      verb_next = '0;
      path_next = '0;
    end else begin
      st_next   = st_upd;
      verb_next = verb_upd;
      path_next = path_upd;
    end
  end

endmodule

// ----- rtl/http_request_line_check_unit.sv -----
// The line_end beat passes the input register and then the result register, which
// raises res_valid; while res_stall holds, the beat waits in the input register.
// Throughput: one byte beat per cycle; the input register, the byte-wise parse and
// the result register each take one beat per cycle, stalled only by res_stall.
// Reset: synchronous rst clears both valid flags, the parse state and the length
// counters; the first beat after reset starts a new request line.
module http_request_line_check_unit #(
  parameter int unsigned LENGTH_WIDTH = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  hrlc_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_stall,
  output hrlc_pkg::res_t  res
);
  import hrlc_pkg::*;

  `include "http_request_line_check_unit_assert.svh"

  logic                    a_valid;
  logic [7:0]              a_byte;
  logic                    a_end;
  logic                    b_adv;
  logic                    consume;

  state_t                  st;
  state_t                  st_next;
  logic [LENGTH_WIDTH-1:0] verb_cnt;
  logic [LENGTH_WIDTH-1:0] verb_next;
  logic [LENGTH_WIDTH-1:0] path_cnt;
  logic [LENGTH_WIDTH-1:0] path_next;
  res_t                    res_next;

  assign b_adv     = !res_valid || !res_stall;
  assign req_stall = a_valid && !b_adv;
  assign consume   = a_valid && b_adv;

  // Input register: hold the beat while the result side is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!req_stall) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      a_byte <= req.line_byte;
      a_end  <= req.line_end;
    end
  end

  hrlc_parse #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parse (
    .st        (st),
    .verb_cnt  (verb_cnt),
    .path_cnt  (path_cnt),
    .line_byte (a_byte),
    .line_end  (a_end),
    .st_next   (st_next),
    .verb_next (verb_next),
    .path_next (path_next),
    .res_next  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_RESET;
      verb_cnt <= '0;
      path_cnt <= '0;
    end else if (consume) begin
      st       <= st_next;
      verb_cnt <= verb_next;
      path_cnt <= path_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_adv) begin
      res_valid <= a_valid && a_end;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && a_end) begin
      res <= res_next;
    end
  end

  `HRLC_ASSERT(a_end_gives_result, consume && a_end |=> res_valid,
               "line end beat produced no result")
  `HRLC_ASSERT(line_end_clears_state,
               consume && a_end |=> st.phase == PH_VERB && verb_cnt == '0 &&
               path_cnt == '0 && !st.ended,
               "parse state not cleared after line end")
  `HRLC_ASSERT_ALWAYS(ok_digits_in_range,
                      res_valid && res.status_code == STS_OK |->
                      res.major_version <= 4'd9 && res.minor_version <= 4'd9,
                      "version digit out of range")
  `HRLC_ASSERT_ALWAYS(err_versions_zero,
                      res_valid && res.status_code != STS_OK |->
                      res.major_version == 4'd0 && res.minor_version == 4'd0,
                      "version fields set on error status")

endmodule
